FILE: rtl/cmqg_pkg.sv
// shared types, constants and helpers for the controlled gate block
package cmqg_pkg;

  localparam int MAX_QUBITS  = 10;
  localparam int MAX_TARGETS = 3;
  localparam int AMP_WIDTH   = 16;
  localparam int FRAC_BITS   = AMP_WIDTH - 2;
  localparam int MAT_SIDE    = 1 << MAX_TARGETS;
  localparam int MAT_DEPTH   = MAT_SIDE * MAT_SIDE;
  localparam int STORE_DEPTH = 1 << MAX_QUBITS;
  localparam int QW          = $clog2(STORE_DEPTH);
  localparam int KW          = MAX_TARGETS;
  localparam int MW          = 2 * MAX_TARGETS;
  localparam int ACC_WIDTH   = AMP_WIDTH + 8;
  localparam int PROD_WIDTH  = 2 * AMP_WIDTH;

  typedef enum logic [1:0] {
    REQ_WR_MAT = 2'd0,
    REQ_WR_AMP = 2'd1,
    REQ_APPLY  = 2'd2,
    REQ_RD_AMP = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BADMASK = 2'd1,
    ST_RANGE   = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    CFG_QUBITS  = 2'd0,
    CFG_TARGETS = 2'd1,
    CFG_CONTROL = 2'd2,
    CFG_PATTERN = 2'd3
  } cfg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE, S_RDWAIT, S_GROUP, S_LOAD, S_LOADW, S_ROW, S_MAC, S_MACW,
    S_PROD, S_WRITE, S_DONE
  } state_t;

  typedef struct packed {
    logic [1:0]                  req_type;
    logic [9:0]                  slot;
    logic signed [AMP_WIDTH-1:0] value_re;
    logic signed [AMP_WIDTH-1:0] value_im;
  } in_beat_t;

  typedef struct packed {
    logic signed [AMP_WIDTH-1:0] out_re;
    logic signed [AMP_WIDTH-1:0] out_im;
    logic [1:0]                  status;
  } out_beat_t;

  // commands from sequencer to the multiply-accumulate unit
  typedef struct packed {
    logic       clear;
    logic       step;
    logic [1:0] phase;
  } mac_ctl_t;

  // deposit the low bits of v into the set positions of mask
  function automatic logic [QW-1:0] deposit(input logic [QW-1:0] v,
                                            input logic [QW-1:0] mask);
    logic [QW-1:0] res;
    int            j;
    res = '0;
    j = 0;
    for (int p = 0; p < QW; p++) begin
      if (mask[p]) begin
        res[p] = v[j];
        j++;
      end
    end
    return res;
  endfunction

  function automatic logic [3:0] popc(input logic [QW-1:0] m);
    logic [3:0] n;
    n = '0;
    for (int p = 0; p < QW; p++) n = n + {3'd0, m[p]};
    return n;
  endfunction

endpackage

FILE: rtl/cmqg_mac.sv
// shared multiplier with rounding and complex accumulation
module cmqg_mac (
  input  logic                                   clk,
  input  cmqg_pkg::mac_ctl_t                     ctl,
  input  logic signed [cmqg_pkg::AMP_WIDTH-1:0]  m_re,
  input  logic signed [cmqg_pkg::AMP_WIDTH-1:0]  m_im,
  input  logic signed [cmqg_pkg::AMP_WIDTH-1:0]  a_re,
  input  logic signed [cmqg_pkg::AMP_WIDTH-1:0]  a_im,
  output logic signed [cmqg_pkg::AMP_WIDTH-1:0]  sum_re,
  output logic signed [cmqg_pkg::AMP_WIDTH-1:0]  sum_im
);
  import cmqg_pkg::*;

  logic signed [AMP_WIDTH-1:0]  op_a, op_b;
  logic signed [PROD_WIDTH-1:0] prod;
  logic signed [PROD_WIDTH-1:0] prod_rnd;
  logic signed [ACC_WIDTH-1:0]  term;
  logic signed [ACC_WIDTH-1:0]  acc_re_r, acc_im_r;
  localparam logic signed [ACC_WIDTH-1:0] SAT_HI = ACC_WIDTH'((1 << (AMP_WIDTH-1)) - 1);
  localparam logic signed [ACC_WIDTH-1:0] SAT_LO = -ACC_WIDTH'(1 << (AMP_WIDTH-1));

  // one real product per step: re*re, im*im, re*im, im*re
  always_comb begin
    case (ctl.phase)
      2'd0:    begin op_a = m_re; op_b = a_re; end
      2'd1:    begin op_a = m_im; op_b = a_im; end
      2'd2:    begin op_a = m_re; op_b = a_im; end
      default: begin op_a = m_im; op_b = a_re; end
    endcase
    prod     = op_a * op_b;
    prod_rnd = (prod + PROD_WIDTH'(1 << (FRAC_BITS-1))) >>> FRAC_BITS;
    term     = ACC_WIDTH'(prod_rnd);
  end

  // accumulate into real or imaginary sum
  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      acc_re_r <= '0;
      acc_im_r <= '0;
    end else if (ctl.step) begin
      case (ctl.phase)
        2'd0:    acc_re_r <= acc_re_r + term;
        2'd1:    acc_re_r <= acc_re_r - term;
        default: acc_im_r <= acc_im_r + term;
      endcase
    end
  end

  // saturate to amplitude range
  always_comb begin
    if (acc_re_r > SAT_HI)      sum_re = SAT_HI[AMP_WIDTH-1:0];
    else if (acc_re_r < SAT_LO) sum_re = SAT_LO[AMP_WIDTH-1:0];
    else                        sum_re = acc_re_r[AMP_WIDTH-1:0];
    if (acc_im_r > SAT_HI)      sum_im = SAT_HI[AMP_WIDTH-1:0];
    else if (acc_im_r < SAT_LO) sum_im = SAT_LO[AMP_WIDTH-1:0];
    else                        sum_im = acc_im_r[AMP_WIDTH-1:0];
  end

endmodule

FILE: rtl/controlled_multi_qubit_gate_apply.sv
// top level: stores, sequencer and result register of the controlled gate block
// Usage: items enter on in_valid/in_stall carrying in_data (req_type, slot, values);
// every item gives one result beat on out_valid/out_stall carrying out_data.
// The user must write configuration through cfg_we/cfg_index/cfg_data only while
// the block is idle; the block itself does not enforce this. Matrix and amplitude
// writes go from acceptance straight to the result state S_DONE; in-range reads
// pass through S_RDWAIT for the registered memory read first. The block takes one
// item at a time and is stalled toward the input (in_stall high) from acceptance
// until the result beat has been taken.
// An apply walks every matching group: per group a check state (S_GROUP), 2^t
// loads (S_LOAD, S_LOADW), then per output row a clear state (S_ROW), 2^t matrix
// terms (S_MAC and S_MACW for the matrix memory read, then four products in S_PROD
// on the single shared multiplier) and a write-back state (S_WRITE), then a closing
// row check in S_ROW. A bad mask goes straight from acceptance to S_DONE.
// Reset (rst_n low, synchronous) restores the configuration and state registers
// and empties the output register; stores hold unspecified data until written.
// When the receiver stalls, the result stays in the output register unchanged
// and no new item is taken.
module controlled_multi_qubit_gate_apply (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  cmqg_pkg::in_beat_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output cmqg_pkg::out_beat_t out_data,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [9:0]          cfg_data
);
  import cmqg_pkg::*;

  logic [3:0]    nq_r;
  logic [QW-1:0] tgt_r, ctl_r, pat_r;
  state_t        state_r, state_nxt;
  in_beat_t      req_r;
  out_beat_t     res_r;
  logic          out_valid_r;

  logic [AMP_WIDTH*2-1:0] amp_mem [STORE_DEPTH];
  logic [AMP_WIDTH*2-1:0] mat_mem [MAT_DEPTH];
  logic [AMP_WIDTH*2-1:0] grp_buf [MAT_SIDE];
  logic [AMP_WIDTH*2-1:0] amp_q_r, mat_q_r;

  logic [QW:0]   grp_r;
  logic [KW:0]   row_r, col_r;
  logic [1:0]    ph_r;

  logic [3:0]    nq_eff;
  logic [QW-1:0] lim, freem, basis;
  logic [3:0]    tcount;
  logic [KW:0]   dim;
  logic [QW:0]   groups;
  logic          bad_mask;
  logic          accept;
  mac_ctl_t      mac_ctl;
  logic signed [AMP_WIDTH-1:0] s_re, s_im;

  // amplitude memory control
  logic          amp_we, amp_re;
  logic [QW-1:0] amp_waddr, amp_raddr;
  logic [AMP_WIDTH*2-1:0] amp_wdata;

  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state_r != S_IDLE) || out_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = res_r;

  // derived mask quantities
  always_comb begin
    nq_eff   = (nq_r > 4'(MAX_QUBITS)) ? 4'(MAX_QUBITS) : nq_r;
    lim      = QW'((1 << nq_eff) - 1);
    tcount   = popc(tgt_r);
    bad_mask = |(tgt_r & ctl_r) || |((tgt_r | ctl_r | pat_r) & ~lim) ||
               |(pat_r & ~ctl_r) || (tcount > 4'(MAX_TARGETS));
    dim      = (KW+1)'(1 << tcount[KW-1:0]);
    freem    = lim & ~(tgt_r | ctl_r);
    groups   = (QW+1)'(1 << popc(freem));
    basis    = deposit(grp_r[QW-1:0], freem) | pat_r;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nq_r  <= 4'd10;
      tgt_r <= QW'(1);
      ctl_r <= '0;
      pat_r <= '0;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_QUBITS:  nq_r  <= cfg_data[3:0];
        CFG_TARGETS: tgt_r <= cfg_data;
        CFG_CONTROL: ctl_r <= cfg_data;
        CFG_PATTERN: pat_r <= cfg_data;
        default:     ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (accept) begin
        if (in_data.req_type == REQ_RD_AMP &&
            {1'b0, in_data.slot} < (QW+1)'(1 << nq_eff)) state_nxt = S_RDWAIT;
        else if (in_data.req_type == REQ_APPLY && !bad_mask) state_nxt = S_GROUP;
        else state_nxt = S_DONE;
      end
      S_RDWAIT: state_nxt = S_DONE;
      S_GROUP:  state_nxt = (grp_r == groups) ? S_DONE : S_LOAD;
      S_LOAD:   state_nxt = S_LOADW;
      S_LOADW:  state_nxt = (col_r + 1'b1 == dim) ? S_ROW : S_LOAD;
      S_ROW:    state_nxt = (row_r == dim) ? S_GROUP : S_MAC;
      S_MAC:    state_nxt = S_MACW;
      S_MACW:   state_nxt = S_PROD;
      S_PROD:   if (ph_r == 2'd3) state_nxt = (col_r + 1'b1 == dim) ? S_WRITE : S_MAC;
      S_WRITE:  state_nxt = S_ROW;
      S_DONE:   state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    amp_we    = 1'b0;
    amp_re    = 1'b0;
    amp_waddr = req_r.slot;
    amp_raddr = in_data.slot;
    amp_wdata = {req_r.value_re, req_r.value_im};
    mac_ctl   = '{clear: 1'b0, step: 1'b0, phase: ph_r};
    case (state_r)
      S_IDLE: amp_re = accept;
      S_LOAD: begin
        amp_re    = 1'b1;
        amp_raddr = basis | deposit(QW'(col_r), tgt_r);
      end
      S_ROW:  mac_ctl.clear = 1'b1;
      S_PROD: mac_ctl.step  = 1'b1;
      S_WRITE: begin
        amp_we    = 1'b1;
        amp_waddr = basis | deposit(QW'(row_r), tgt_r);
        amp_wdata = {s_re, s_im};
      end
      S_DONE: amp_we = (req_r.req_type == REQ_WR_AMP) &&
                       ({1'b0, req_r.slot} < (QW+1)'(1 << nq_eff));
      default: ;
    endcase
  end

  // sequencer registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // counters and request hold
  always_ff @(posedge clk) begin
    if (accept) begin
      req_r <= in_data;
      grp_r <= '0;
    end
    case (state_r)
      S_GROUP: begin
        col_r <= '0;
        row_r <= '0;
      end
      S_LOADW: begin
        grp_buf[col_r[KW-1:0]] <= amp_q_r;
        col_r <= col_r + 1'b1;
      end
      S_ROW:  col_r <= '0;
      S_PROD: begin
        ph_r <= ph_r + 2'd1;
        if (ph_r == 2'd3) col_r <= col_r + 1'b1;
      end
      S_MAC:  ph_r <= 2'd0;
      S_WRITE: row_r <= row_r + 1'b1;
      default: ;
    endcase
    if (state_r == S_ROW && row_r == dim) grp_r <= grp_r + 1'b1;
  end

  // amplitude memory
  always_ff @(posedge clk) begin
    if (amp_we) amp_mem[amp_waddr] <= amp_wdata;
    if (amp_re) amp_q_r <= amp_mem[amp_raddr];
  end

  // matrix memory
  always_ff @(posedge clk) begin
    if (state_r == S_DONE && req_r.req_type == REQ_WR_MAT && req_r.slot < 10'(MAT_DEPTH))
      mat_mem[req_r.slot[MW-1:0]] <= {req_r.value_re, req_r.value_im};
    if (state_r == S_MAC)
      mat_q_r <= mat_mem[{row_r[KW-1:0], col_r[KW-1:0]}];
  end

  cmqg_mac u_mac (
    .clk    (clk),
    .ctl    (mac_ctl),
    .m_re   (mat_q_r[AMP_WIDTH*2-1:AMP_WIDTH]),
    .m_im   (mat_q_r[AMP_WIDTH-1:0]),
    .a_re   (grp_buf[col_r[KW-1:0]][AMP_WIDTH*2-1:AMP_WIDTH]),
    .a_im   (grp_buf[col_r[KW-1:0]][AMP_WIDTH-1:0]),
    .sum_re (s_re),
    .sum_im (s_im)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_DONE) begin
      out_valid_r <= 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_DONE) begin
      res_r.out_re <= '0;
      res_r.out_im <= '0;
      res_r.status <= ST_OK;
      case (req_t'(req_r.req_type))
        REQ_WR_MAT: if (req_r.slot >= 10'(MAT_DEPTH)) res_r.status <= ST_RANGE;
        REQ_WR_AMP: if ({1'b0, req_r.slot} >= (QW+1)'(1 << nq_eff)) res_r.status <= ST_RANGE;
        REQ_APPLY:  if (bad_mask) res_r.status <= ST_BADMASK;
        REQ_RD_AMP: begin
          if ({1'b0, req_r.slot} >= (QW+1)'(1 << nq_eff)) begin
            res_r.status <= ST_RANGE;
          end else begin
            res_r.out_re <= amp_q_r[AMP_WIDTH*2-1:AMP_WIDTH];
            res_r.out_im <= amp_q_r[AMP_WIDTH-1:0];
          end
        end
        default: ;
      endcase
    end
  end

endmodule
